@@ hw/rtl/rational_arith_unit_core_assert.svh @@
// assertion macros shared by the rational arithmetic unit
`ifndef RATIONAL_ARITH_UNIT_CORE_ASSERT_SVH
`define RATIONAL_ARITH_UNIT_CORE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define RAU_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define RAU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ hw/rtl/rau_pkg.sv @@
// shared types and codes for the rational arithmetic unit
package rau_pkg;

   localparam int WORD_BITS_DEF = 32;
   localparam int FIELD_BITS    = 32;
   localparam int DEN_OUT_BITS  = 31;
   localparam int IN_DATA_BITS  = 4 * FIELD_BITS;
   localparam int OUT_DATA_BITS = 64;

   localparam logic [1:0] KIND_ADD = 2'd0;
   localparam logic [1:0] KIND_SUB = 2'd1;
   localparam logic [1:0] KIND_MUL = 2'd2;
   localparam logic [1:0] KIND_DIV = 2'd3;

   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_ZERO_DEN = 2'd1;
   localparam logic [1:0] ERR_OVERFLOW = 2'd2;

   localparam logic [3:0] OP_NONE      = 4'd0;
   localparam logic [3:0] OP_LOAD      = 4'd1;
   localparam logic [3:0] OP_MUL0      = 4'd2;
   localparam logic [3:0] OP_MUL1      = 4'd3;
   localparam logic [3:0] OP_MUL2      = 4'd4;
   localparam logic [3:0] OP_COMB      = 4'd5;
   localparam logic [3:0] OP_GCD_INIT  = 4'd6;
   localparam logic [3:0] OP_GCD_STEP  = 4'd7;
   localparam logic [3:0] OP_DIV_INIT  = 4'd8;
   localparam logic [3:0] OP_DIV_STEP  = 4'd9;
   localparam logic [3:0] OP_EMIT      = 4'd10;

   typedef struct packed {
      logic [3:0] op;
   } cmd_type;

   typedef struct packed {
      logic err_zero;
      logic mag_zero;
      logic gcd_done;
      logic div_last;
      logic out_free;
   } status_type;

endpackage

@@ hw/rtl/rational_arith_unit_core.sv @@
// top level of the rational arithmetic unit
// sequence: load, three multiply steps, combine, the binary gcd loop, the bit-serial dividers
// and emit; a zero denominator or a zero result goes straight to emit
// throughput: one item at a time, next item taken once the result is registered
// reset: synchronous, clears the state machine and the result valid flag
module rational_arith_unit_core #(
   parameter int WORD_BITS = rau_pkg::WORD_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // left_num, left_den, right_num, right_den
   input  logic [rau_pkg::IN_DATA_BITS-1:0]  req_tdata,
   // kind
   input  logic [1:0]                        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // result_num, result_den, zero pad
   output logic [rau_pkg::OUT_DATA_BITS-1:0] rsp_tdata,
   // error_code
   output logic [1:0]                        rsp_tuser
);

   rau_pkg::cmd_type    cmd;
   rau_pkg::status_type status;

   rau_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   rau_datapath #(
      .WORD_BITS (WORD_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .in_kind    (req_tuser),
      .in_data    (req_tdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

@@ hw/rtl/rau_ctrl.sv @@
// sequencing state machine of the rational arithmetic unit
module rau_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  rau_pkg::status_type status,
   output rau_pkg::cmd_type    cmd
);

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_MUL0 = 4'd1;
   localparam logic [3:0] ST_MUL1 = 4'd2;
   localparam logic [3:0] ST_MUL2 = 4'd3;
   localparam logic [3:0] ST_COMB = 4'd4;
   localparam logic [3:0] ST_GCDI = 4'd5;
   localparam logic [3:0] ST_GCDS = 4'd6;
   localparam logic [3:0] ST_DIVS = 4'd7;
   localparam logic [3:0] ST_EMIT = 4'd8;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd.op   = rau_pkg::OP_NONE;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.op   = rau_pkg::OP_LOAD;
               state_in = ST_MUL0;
            end
         end
         ST_MUL0: begin
            if (status.err_zero) begin
               state_in = ST_EMIT;
            end else begin
               cmd.op   = rau_pkg::OP_MUL0;
               state_in = ST_MUL1;
            end
         end
         ST_MUL1: begin
            cmd.op   = rau_pkg::OP_MUL1;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            cmd.op   = rau_pkg::OP_MUL2;
            state_in = ST_COMB;
         end
         ST_COMB: begin
            cmd.op   = rau_pkg::OP_COMB;
            state_in = ST_GCDI;
         end
         ST_GCDI: begin
            if (status.mag_zero) begin
               state_in = ST_EMIT;
            end else begin
               cmd.op   = rau_pkg::OP_GCD_INIT;
               state_in = ST_GCDS;
            end
         end
         ST_GCDS: begin
            if (status.gcd_done) begin
               cmd.op   = rau_pkg::OP_DIV_INIT;
               state_in = ST_DIVS;
            end else begin
               cmd.op = rau_pkg::OP_GCD_STEP;
            end
         end
         ST_DIVS: begin
            cmd.op = rau_pkg::OP_DIV_STEP;
            if (status.div_last) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.op   = rau_pkg::OP_EMIT;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ hw/rtl/rau_datapath.sv @@
// operand registers, shared multiplier, binary gcd, dividers and result register
`include "rational_arith_unit_core_assert.svh"

module rau_datapath #(
   parameter int WORD_BITS = rau_pkg::WORD_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  rau_pkg::cmd_type                     cmd,
   output rau_pkg::status_type                  status,
   input  logic [1:0]                           in_kind,
   input  logic [rau_pkg::IN_DATA_BITS-1:0]     in_data,
   input  logic                                 rsp_tready,
   output logic                                 rsp_tvalid,
   output logic [rau_pkg::OUT_DATA_BITS-1:0]    rsp_tdata,
   output logic [1:0]                           rsp_tuser
);

   localparam int W  = WORD_BITS;
   localparam int FB = rau_pkg::FIELD_BITS;
   localparam int DW = 2 * W;
   localparam int MW = 2 * W + 1;
   localparam int KW = $clog2(DW + 1);
   localparam int CW = $clog2(MW);

   // operand split
   logic [W-1:0] raw_ln, raw_ld, raw_rn, raw_rd;
   logic         ln_neg, ld_neg, rn_neg, rd_neg;
   logic [W-1:0] ln_mag, ld_mag, rn_mag, rd_mag;

   assign raw_ln = in_data[W-1:0];
   assign raw_ld = in_data[FB+W-1:FB];
   assign raw_rn = in_data[2*FB+W-1:2*FB];
   assign raw_rd = in_data[3*FB+W-1:3*FB];
   assign ln_neg = raw_ln[W-1];
   assign ld_neg = raw_ld[W-1];
   assign rn_neg = raw_rn[W-1];
   assign rd_neg = raw_rd[W-1];
   assign ln_mag = (raw_ln ^ {W{ln_neg}}) + W'(ln_neg);
   assign ld_mag = (raw_ld ^ {W{ld_neg}}) + W'(ld_neg);
   assign rn_mag = (raw_rn ^ {W{rn_neg}}) + W'(rn_neg);
   assign rd_mag = (raw_rd ^ {W{rd_neg}}) + W'(rd_neg);

   logic [1:0]    kind_ff, kind_in;
   logic          sa_ff, sa_in, sb_ff, sb_in, neg_ff, neg_in;
   logic          err_zero_ff, err_zero_in;
   logic [W-1:0]  na_ff, na_in, da_ff, da_in, nb_ff, nb_in, db_ff, db_in;
   logic [DW-1:0] p_ff, p_in, q_ff, q_in, den_ff, den_in;
   logic [MW-1:0] mag_ff, mag_in;
   logic [MW-1:0] u_ff, u_in, v_ff, v_in;
   logic [KW-1:0] k_ff, k_in;
   logic [MW-1:0] g_ff, g_in;
   logic [MW-1:0] qa_ff, qa_in, qb_ff, qb_in, ra_ff, ra_in, rb_ff, rb_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          rsp_tvalid_ff, rsp_tvalid_in;
   logic [FB-1:0] num_ff, num_in;
   logic [rau_pkg::DEN_OUT_BITS-1:0] den_out_ff, den_out_in;
   logic [1:0]    code_ff, code_in;

   // shared multiplier
   logic [W-1:0]  mul_a, mul_b;
   logic [DW-1:0] mul_p;

   always_comb begin
      mul_a = da_ff;
      mul_b = (kind_ff == rau_pkg::KIND_DIV) ? nb_ff : db_ff;
      if (cmd.op == rau_pkg::OP_MUL0) begin
         mul_a = na_ff;
         mul_b = (kind_ff == rau_pkg::KIND_MUL) ? nb_ff : db_ff;
      end else if (cmd.op == rau_pkg::OP_MUL1) begin
         mul_a = nb_ff;
         mul_b = da_ff;
      end
   end

   assign mul_p = DW'(mul_a) * DW'(mul_b);

   // gcd and divider helpers
   logic          both_odd, u_gt_v;
   logic [MW:0]   ta, tb;
   logic          ge_a, ge_b;
   logic [MW-1:0] sum_pq;
   logic          p_ge_q;
   logic          den_ovf, mag_ovf;
   logic [W-1:0]  res_w;

   assign both_odd = u_ff[0] & v_ff[0];
   assign u_gt_v   = u_ff > v_ff;
   assign ta       = {ra_ff, qa_ff[MW-1]};
   assign tb       = {rb_ff, qb_ff[MW-1]};
   assign ge_a     = ta >= {1'b0, g_ff};
   assign ge_b     = tb >= {1'b0, g_ff};
   assign sum_pq   = {1'b0, p_ff} + {1'b0, q_ff};
   assign p_ge_q   = p_ff >= q_ff;
   assign den_ovf  = |qb_ff[MW-1:W-1];
   assign mag_ovf  = neg_ff ? (|qa_ff[MW-1:W] | (qa_ff[W-1] & |qa_ff[W-2:0]))
                            : |qa_ff[MW-1:W-1];
   assign res_w    = neg_ff ? (~qa_ff[W-1:0] + W'(1)) : qa_ff[W-1:0];

   always_comb begin
      kind_in     = kind_ff;
      sa_in       = sa_ff;
      sb_in       = sb_ff;
      neg_in      = neg_ff;
      err_zero_in = err_zero_ff;
      na_in       = na_ff;
      da_in       = da_ff;
      nb_in       = nb_ff;
      db_in       = db_ff;
      p_in        = p_ff;
      q_in        = q_ff;
      den_in      = den_ff;
      mag_in      = mag_ff;
      u_in        = u_ff;
      v_in        = v_ff;
      k_in        = k_ff;
      g_in        = g_ff;
      qa_in       = qa_ff;
      qb_in       = qb_ff;
      ra_in       = ra_ff;
      rb_in       = rb_ff;
      cnt_in      = cnt_ff;
      num_in      = num_ff;
      den_out_in  = den_out_ff;
      code_in     = code_ff;
      rsp_tvalid_in = rsp_tready ? 1'b0 : rsp_tvalid_ff;
      case (cmd.op)
         rau_pkg::OP_LOAD: begin
            kind_in     = in_kind;
            na_in       = ln_mag;
            da_in       = ld_mag;
            nb_in       = rn_mag;
            db_in       = rd_mag;
            sa_in       = ln_neg ^ ld_neg;
            sb_in       = rn_neg ^ rd_neg ^ (in_kind == rau_pkg::KIND_SUB);
            err_zero_in = (ld_mag == '0) || (rd_mag == '0)
                          || ((in_kind == rau_pkg::KIND_DIV) && (rn_mag == '0));
         end
         rau_pkg::OP_MUL0: begin
            p_in = mul_p;
         end
         rau_pkg::OP_MUL1: begin
            q_in = mul_p;
         end
         rau_pkg::OP_MUL2: begin
            den_in = mul_p;
         end
         rau_pkg::OP_COMB: begin
            if (kind_ff == rau_pkg::KIND_ADD || kind_ff == rau_pkg::KIND_SUB) begin
               if (sa_ff == sb_ff) begin
                  mag_in = sum_pq;
                  neg_in = sa_ff;
               end else if (p_ge_q) begin
                  mag_in = MW'(p_ff - q_ff);
                  neg_in = sa_ff;
               end else begin
                  mag_in = MW'(q_ff - p_ff);
                  neg_in = sb_ff;
               end
            end else begin
               mag_in = MW'(p_ff);
               neg_in = sa_ff ^ sb_ff;
            end
         end
         rau_pkg::OP_GCD_INIT: begin
            u_in = mag_ff;
            v_in = MW'(den_ff);
            k_in = '0;
         end
         rau_pkg::OP_GCD_STEP: begin
            if (!u_ff[0] && !v_ff[0]) begin
               u_in = u_ff >> 1;
               v_in = v_ff >> 1;
               k_in = k_ff + KW'(1);
            end else if (!u_ff[0]) begin
               u_in = u_ff >> 1;
            end else if (!v_ff[0]) begin
               v_in = v_ff >> 1;
            end else if (both_odd && u_gt_v) begin
               u_in = u_ff - v_ff;
            end else begin
               v_in = v_ff - u_ff;
            end
         end
         rau_pkg::OP_DIV_INIT: begin
            g_in   = u_ff << k_ff;
            qa_in  = mag_ff;
            qb_in  = MW'(den_ff);
            ra_in  = '0;
            rb_in  = '0;
            cnt_in = '0;
         end
         rau_pkg::OP_DIV_STEP: begin
            ra_in  = ge_a ? MW'(ta - {1'b0, g_ff}) : MW'(ta);
            rb_in  = ge_b ? MW'(tb - {1'b0, g_ff}) : MW'(tb);
            qa_in  = {qa_ff[MW-2:0], ge_a};
            qb_in  = {qb_ff[MW-2:0], ge_b};
            cnt_in = cnt_ff + CW'(1);
         end
         rau_pkg::OP_EMIT: begin
            rsp_tvalid_in = 1'b1;
            num_in        = '0;
            den_out_in    = rau_pkg::DEN_OUT_BITS'(1);
            if (err_zero_ff) begin
               code_in = rau_pkg::ERR_ZERO_DEN;
            end else if (mag_ff == '0) begin
               code_in = rau_pkg::ERR_NONE;
            end else if (den_ovf || mag_ovf) begin
               code_in = rau_pkg::ERR_OVERFLOW;
            end else begin
               code_in    = rau_pkg::ERR_NONE;
               num_in     = FB'($signed(res_w));
               den_out_in = rau_pkg::DEN_OUT_BITS'(qb_ff[W-1:0]);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      sa_ff       <= sa_in;
      sb_ff       <= sb_in;
      neg_ff      <= neg_in;
      err_zero_ff <= err_zero_in;
      na_ff       <= na_in;
      da_ff       <= da_in;
      nb_ff       <= nb_in;
      db_ff       <= db_in;
      p_ff        <= p_in;
      q_ff        <= q_in;
      den_ff      <= den_in;
      mag_ff      <= mag_in;
      u_ff        <= u_in;
      v_ff        <= v_in;
      k_ff        <= k_in;
      g_ff        <= g_in;
      qa_ff       <= qa_in;
      qb_ff       <= qb_in;
      ra_ff       <= ra_in;
      rb_ff       <= rb_in;
      cnt_ff      <= cnt_in;
      num_ff      <= num_in;
      den_out_ff  <= den_out_in;
      code_ff     <= code_in;
   end

   assign status.err_zero = err_zero_ff;
   assign status.mag_zero = (mag_ff == '0);
   assign status.gcd_done = (u_ff == v_ff);
   assign status.div_last = (cnt_ff == CW'(MW - 1));
   assign status.out_free = !rsp_tvalid_ff || rsp_tready;

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {1'b0, den_out_ff, num_ff};
   assign rsp_tuser  = code_ff;

   `RAU_ASSERT_NEXT(a_gcd_nonzero, clock, reset, cmd.op == rau_pkg::OP_GCD_STEP, (u_ff != '0) && (v_ff != '0))
   `RAU_ASSERT_NEXT(a_emit_valid, clock, reset, cmd.op == rau_pkg::OP_EMIT, rsp_tvalid)
   `RAU_ASSERT_SAME(a_err_zero_frac, clock, reset, rsp_tvalid && (rsp_tuser != rau_pkg::ERR_NONE), (num_ff == '0) && (den_out_ff == rau_pkg::DEN_OUT_BITS'(1)))

endmodule
